// File: sv/b64fd_pkg.sv
// Shared types, constants and functions of the base64url frame decoder.
package b64fd_pkg;

  localparam int unsigned TEXT_CHARS  = 60;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned ACC_W       = 18;
  localparam int unsigned FINAL_GROUP = TEXT_CHARS / 4 - 1;
  localparam logic [7:0]  CRC_POLY    = 8'h07;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_VERSION  = 2'd2,
    ST_CRC      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BND_BAD   = 2'd0,
    BND_DATA  = 2'd1,
    BND_FINAL = 2'd2
  } bnd_e;

  typedef struct packed {
    bnd_e       kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    status_e    st;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r.ok  = 1'b1;
    r.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2D) begin
      r.val = 6'd62;
    end else if (c == 8'h5F) begin
      r.val = 6'd63;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: sv/b64fd_char_if.sv
// Input channel carrying one text character per word.
interface b64fd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

// File: sv/b64fd_res_if.sv
// Result channel carrying one decoded byte or frame status per word.
interface b64fd_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output kind, output byte_value, output status,
                  output last, input ready);
  modport sink   (input valid, input kind, input byte_value, input status,
                  input last, output ready);
endinterface

// File: sv/b64fd_cfg_if.sv
// Configuration write channel for the expected version register.
interface b64fd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] expected_version;

  modport source (output valid, output expected_version, input ready);
  modport sink   (input valid, input expected_version, output ready);
endinterface

// File: sv/b64fd_group.sv
// Frame state, character decode, CRC and result bundle construction.
module b64fd_group (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          ch_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i,
  output logic                push_o,
  output b64fd_pkg::bundle_t  bundle_o
);
  import b64fd_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [7:0]       crc_q, crc_d;
  logic             drop_q, drop_d;
  logic [7:0]       ver_q;

  sextet_t    sx;
  logic       frame_end;
  logic       final_group;
  logic [7:0] b0, b1, b2, crc01;

  assign sx          = sextet_of(ch_i);
  assign frame_end   = pos_q >= POS_W'(TEXT_CHARS - 1);
  assign final_group = pos_q[POS_W-1:2] >= (POS_W-2)'(FINAL_GROUP);
  assign b0          = acc_q[17:10];
  assign b1          = acc_q[9:2];
  assign b2          = {acc_q[1:0], sx.val};
  assign crc01       = crc8_byte(crc8_byte(crc_q, b0), b1);

  always_comb begin
    pos_d    = pos_q;
    acc_d    = acc_q;
    crc_d    = crc_q;
    drop_d   = drop_q;
    push_o   = 1'b0;
    bundle_o = '{kind: BND_BAD, b0: b0, b1: b1, b2: b2, st: ST_BAD_CHAR};
    if (accept_i) begin
      pos_d = POS_W'(pos_q + 1'b1);
      if (drop_q) begin
        // Rest of the frame is swallowed.
      end else if (!sx.ok) begin
        push_o = 1'b1;
        drop_d = 1'b1;
      end else if (pos_q[1:0] != 2'd3) begin
        acc_d = {acc_q[ACC_W-7:0], sx.val};
      end else begin
        acc_d  = '0;
        push_o = 1'b1;
        if (!final_group) begin
          crc_d         = crc8_byte(crc01, b2);
          bundle_o.kind = BND_DATA;
          bundle_o.st   = ST_OK;
        end else begin
          crc_d         = crc01;
          drop_d        = 1'b1;
          bundle_o.kind = BND_FINAL;
          if (b1 != ver_q) begin
            bundle_o.st = ST_VERSION;
          end else if (b2 != crc01) begin
            bundle_o.st = ST_CRC;
          end else begin
            bundle_o.st = ST_OK;
          end
        end
      end
      if (frame_end) begin
        pos_d  = '0;
        acc_d  = '0;
        crc_d  = '0;
        drop_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      acc_q  <= '0;
      crc_q  <= '0;
      drop_q <= 1'b0;
      ver_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      acc_q  <= acc_d;
      crc_q  <= crc_d;
      drop_q <= drop_d;
      if (cfg_we_i) begin
        ver_q <= cfg_data_i;
      end
    end
  end

endmodule

// File: sv/b64fd_out_ser.sv
// Result register that sends a bundle out one word per cycle while the result sink is ready.
module b64fd_out_ser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64fd_pkg::bundle_t  bundle_i,
  output logic                load_ok_o,
  b64fd_res_if.source         res
);
  import b64fd_pkg::*;

  logic       vld_q;
  logic [1:0] idx_q;
  bundle_t    bnd_q;
  logic       last_word;

  always_comb begin
    res.kind       = KIND_DATA;
    res.byte_value = 8'd0;
    res.status     = ST_OK;
    last_word      = 1'b0;
    unique case (bnd_q.kind)
      BND_BAD: begin
        res.kind   = KIND_STATUS;
        res.status = ST_BAD_CHAR;
        last_word  = 1'b1;
      end
      BND_DATA, BND_FINAL: begin
        unique case (idx_q)
          2'd0: res.byte_value = bnd_q.b0;
          2'd1: res.byte_value = bnd_q.b1;
          2'd2: begin
            res.byte_value = bnd_q.b2;
            last_word      = (bnd_q.kind == BND_DATA);
          end
          default: begin
            res.kind   = KIND_STATUS;
            res.status = bnd_q.st;
            last_word  = 1'b1;
          end
        endcase
      end
      default: last_word = 1'b1;
    endcase
  end

  assign res.valid = vld_q;
  assign res.last  = last_word;
  assign load_ok_o = !vld_q || (res.ready && last_word);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (load_ok_o) begin
      vld_q <= push_i;
      idx_q <= '0;
    end else if (res.ready) begin
      idx_q <= 2'(idx_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok_o && push_i) begin
      bnd_q <= bundle_i;
    end
  end

endmodule

// File: sv/base64url_frame_decoder_crc8_core.sv
// Top level of the base64url frame decoder with CRC-8 check.
// One character is taken per cycle while the output register can load;
// characters that complete no group leave no result. A character that
// closes a group turns into three data words, plus a status word for the
// final group, held in one output register that sends a word per cycle while
// the result sink is ready; the next character is taken in the cycle its last
// word leaves. A bad character gives one status word at once and the rest
// of the frame is swallowed. The configuration port is always ready and
// should be written only while no frame word is pending.
module base64url_frame_decoder_crc8_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64fd_char_if.sink  ch_i,
  b64fd_cfg_if.sink   cfg_i,
  b64fd_res_if.source res_o
);
  import b64fd_pkg::*;

  logic    load_ok;
  logic    push;
  logic    accept;
  bundle_t bundle;

  assign ch_i.ready  = load_ok;
  assign accept      = ch_i.valid && load_ok;
  assign cfg_i.ready = 1'b1;

  b64fd_group u_group (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .ch_i       (ch_i.ch),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.expected_version),
    .push_o     (push),
    .bundle_o   (bundle)
  );

  b64fd_out_ser u_out_ser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .bundle_i  (bundle),
    .load_ok_o (load_ok),
    .res       (res_o)
  );

endmodule

// File: sv/b64fd_checker.sv
// Port-level checks on the result channel of the frame decoder.
module b64fd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic       kind_i,
  input logic [7:0] byte_value_i,
  input logic [1:0] status_i,
  input logic       last_i
);
  import b64fd_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && kind_i == KIND_STATUS |-> last_i)
    else $error("Status word is not marked last.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && kind_i == KIND_STATUS |-> byte_value_i == 8'd0)
    else $error("Status word carries a nonzero byte.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && kind_i == KIND_DATA |-> status_i == ST_OK)
    else $error("Data word carries a status.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(kind_i) && $stable(byte_value_i)
      && $stable(status_i) && $stable(last_i))
    else $error("Stalled result word changed.");

endmodule

bind base64url_frame_decoder_crc8_core b64fd_checker u_b64fd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (res_o.valid),
  .ready_i      (res_o.ready),
  .kind_i       (res_o.kind),
  .byte_value_i (res_o.byte_value),
  .status_i     (res_o.status),
  .last_i       (res_o.last)
);
